// ===== sv/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

   // request action codes
   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_EXTRACT = 2'd1,
      ACT_MODIFY  = 2'd2,
      ACT_PEEK    = 2'd3
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 5;

   // one stored (element, key) pair
   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic signed [DATA_W-1:0] key;
   } pair_type;

   // result of the shared compare unit
   typedef struct packed {
      logic key_lt;
      logic elem_eq;
   } cmp_type;

endpackage

// ===== sv/sapq_req_if.sv =====
// ----------------------------------------------------------------------------
// sapq_req_if
// Request channel: valid/ready handshake with action, element and key.
// ----------------------------------------------------------------------------
interface sapq_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic signed [31:0]  element;
   logic signed [31:0]  key;

   modport source (output valid, action, element, key, input ready);
   modport sink   (input valid, action, element, key, output ready);
endinterface

// ===== sv/sapq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sapq_rsp_if
// Response channel: valid/ready handshake with status and queue summary.
// ----------------------------------------------------------------------------
interface sapq_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic signed [31:0]  element_out;
   logic [4:0]          count;
   logic signed [31:0]  highest_key;
   logic signed [31:0]  lowest_key;

   modport source (output valid, status, element_out, count, highest_key, lowest_key,
                   input ready);
   modport sink   (input valid, status, element_out, count, highest_key, lowest_key,
                   output ready);
endinterface

// ===== sv/sapq_store.sv =====
// ----------------------------------------------------------------------------
// sapq_store
// Pair storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sapq_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  sapq_pkg::pair_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output sapq_pkg::pair_type rd_data
);
   import sapq_pkg::*;

   pair_type mem [DEPTH];
   pair_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/sapq_cmp.sv =====
// ----------------------------------------------------------------------------
// sapq_cmp
// Shared compare unit: signed key order and element match against the request.
// ----------------------------------------------------------------------------
module sapq_cmp (
   input  sapq_pkg::pair_type          stored,
   input  logic signed [31:0]          req_key,
   input  logic signed [31:0]          req_element,
   output sapq_pkg::cmp_type           result
);
   import sapq_pkg::*;

   // stored key strictly below the request key, and element match
   always_comb begin
      result.key_lt  = (stored.key < req_key);
      result.elem_eq = (stored.element == req_element);
   end
endmodule

// ===== sv/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Priority queue of (element, key) pairs kept sorted by key, highest first,
// in a memory with one read and one write port, walked one slot at a time
// by a small sequencer.
// ----------------------------------------------------------------------------
// channel  | dir | handshake     | payload
// req_ch   | in  | valid / ready | action, element, key
// rsp_ch   | out | valid / ready | status, element_out, count, highest_key,
//          |     |               | lowest_key
//
// Each slot visited takes a registered read, then a compare and move.
// Reset clears the count, sequencer and response valid; storage is not cleared.
// A request is taken while a response waits; the next result holds until then.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   sapq_req_if.sink   req_ch,
   sapq_rsp_if.source rsp_ch
);
   import sapq_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_EXT_HEAD, S_EXT_RD, S_EXT_MOVE,
      S_MOD_RD, S_MOD_CHK, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
      S_FIN_HEAD, S_FIN_LOW, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             moved_ff, moved_in;
   logic             extracted_ff, extracted_in;
   status_type       status_ff, status_in;
   logic signed [31:0] op_elem_ff, op_elem_in;
   logic signed [31:0] op_key_ff, op_key_in;
   logic signed [31:0] ext_elem_ff, ext_elem_in;
   pair_type         head_ff, head_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_elem_ff, rsp_elem_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic signed [31:0] rsp_high_ff, rsp_high_in;
   logic signed [31:0] rsp_low_ff, rsp_low_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   pair_type         wr_data;
   logic [AW-1:0]    rd_addr;
   pair_type         rd_data;
   cmp_type          cmp;

   pair_type         new_pair;
   logic [CW-1:0]    idx_dec;
   logic [CW-1:0]    idx_inc;
   logic [CW-1:0]    count_dec;
   logic [PW-1:0]    count_pad;
   logic             req_fire;

   sapq_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sapq_cmp u_cmp (
      .stored     (rd_data),
      .req_key    (op_key_ff),
      .req_element(op_elem_ff),
      .result     (cmp)
   );

   assign req_fire         = req_ch.valid && req_ch.ready;
   assign req_ch.ready     = (state_ff == S_IDLE);
   assign new_pair.element = op_elem_ff;
   assign new_pair.key     = op_key_ff;
   assign idx_dec          = idx_ff - ONE_C;
   assign idx_inc          = idx_ff + ONE_C;
   assign count_dec        = count_ff - ONE_C;
   assign count_pad        = PW'(count_ff);

   // sequencer next-state and memory control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      moved_in      = moved_ff;
      extracted_in  = extracted_ff;
      status_in     = status_ff;
      op_elem_in    = op_elem_ff;
      op_key_in     = op_key_ff;
      ext_elem_in   = ext_elem_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = new_pair;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_elem_in   = req_ch.element;
               op_key_in    = req_ch.key;
               status_in    = ST_OK;
               extracted_in = 1'b0;
               moved_in     = 1'b0;
               idx_in       = '0;
               unique case (action_type'(req_ch.action))
                  ACT_INSERT: begin
                     if (count_ff == CAP_C) begin
                        status_in = ST_FULL;
                        state_in  = S_FIN_HEAD;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  ACT_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FIN_HEAD;
                     end else begin
                        state_in = S_EXT_HEAD;
                     end
                  end
                  ACT_MODIFY: begin
                     state_in = S_MOD_RD;
                  end
                  ACT_PEEK: begin
                     state_in = S_FIN_HEAD;
                  end
                  default: begin
                     state_in = S_FIN_HEAD;
                  end
               endcase
            end
            // slot 0 is read early for an extract
            rd_addr = '0;
         end

         // insert: walk the hole up past strictly smaller keys
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + ONE_C;
               state_in = S_FIN_HEAD;
            end else begin
               rd_addr  = idx_dec[AW-1:0];
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp.key_lt) begin
               wr_data  = rd_data;
               idx_in   = idx_dec;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + ONE_C;
               state_in = S_FIN_HEAD;
            end
         end

         // extract: take slot 0, then shift the rest down by one
         S_EXT_HEAD: begin
            ext_elem_in  = rd_data.element;
            extracted_in = 1'b1;
            state_in     = S_EXT_RD;
         end
         S_EXT_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_dec;
               state_in = S_FIN_HEAD;
            end else begin
               rd_addr  = idx_inc[AW-1:0];
               state_in = S_EXT_MOVE;
            end
         end
         S_EXT_MOVE: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_inc;
            state_in = S_EXT_RD;
         end

         // modify: search from slot 0 for the first matching element
         S_MOD_RD: begin
            if (idx_ff == count_ff) begin
               status_in = ST_MISSING;
               state_in  = S_FIN_HEAD;
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_MOD_CHK;
            end
         end
         S_MOD_CHK: begin
            if (cmp.elem_eq) begin
               state_in = S_UP_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_MOD_RD;
            end
         end

         // modify: move up past strictly smaller keys
         S_UP_RD: begin
            if (idx_ff == '0) begin
               if (moved_ff) begin
                  wr_en    = 1'b1;
                  state_in = S_FIN_HEAD;
               end else begin
                  state_in = S_DN_RD;
               end
            end else begin
               rd_addr  = idx_dec[AW-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (cmp.key_lt) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = idx_dec;
               moved_in = 1'b1;
               state_in = S_UP_RD;
            end else if (moved_ff) begin
               wr_en    = 1'b1;
               state_in = S_FIN_HEAD;
            end else begin
               state_in = S_DN_RD;
            end
         end

         // modify: move down past greater-or-equal keys
         S_DN_RD: begin
            if (idx_inc >= count_ff) begin
               wr_en    = 1'b1;
               state_in = S_FIN_HEAD;
            end else begin
               rd_addr  = idx_inc[AW-1:0];
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (!cmp.key_lt) begin
               wr_data  = rd_data;
               idx_in   = idx_inc;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN_HEAD;
            end
         end

         // summary: read head and tail of the queue
         S_FIN_HEAD: begin
            rd_addr  = '0;
            state_in = S_FIN_LOW;
         end
         S_FIN_LOW: begin
            head_in  = rd_data;
            rd_addr  = count_dec[AW-1:0];
            state_in = S_DONE;
         end
         // tail pair stays on the read port while its address is held
         S_DONE: begin
            rd_addr = count_dec[AW-1:0];
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_pad[COUNT_W-1:0];
               if (count_ff == '0) begin
                  rsp_high_in = '0;
                  rsp_low_in  = '0;
               end else begin
                  rsp_high_in = head_ff.key;
                  rsp_low_in  = rd_data.key;
               end
               if (extracted_ff) begin
                  rsp_elem_in = ext_elem_ff;
               end else if (count_ff == '0) begin
                  rsp_elem_in = '0;
               end else begin
                  rsp_elem_in = head_ff.element;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      moved_ff      <= moved_in;
      extracted_ff  <= extracted_in;
      status_ff     <= status_in;
      op_elem_ff    <= op_elem_in;
      op_key_ff     <= op_key_in;
      ext_elem_ff   <= ext_elem_in;
      head_ff       <= head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_low_ff    <= rsp_low_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.element_out = rsp_elem_ff;
   assign rsp_ch.count       = rsp_count_ff;
   assign rsp_ch.highest_key = rsp_high_ff;
   assign rsp_ch.lowest_key  = rsp_low_ff;
endmodule

// ===== sv/sapq_chk.sv =====
// ----------------------------------------------------------------------------
// sapq_chk
// Port-level checks on the priority queue response channel, bound to the top.
// ----------------------------------------------------------------------------
module sapq_chk #(
   parameter int unsigned CAPACITY = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic signed [31:0] rsp_element_out,
   input logic [4:0]        rsp_count,
   input logic signed [31:0] rsp_highest_key,
   input logic signed [31:0] rsp_lowest_key
);
   import sapq_pkg::*;

   localparam logic SMALL_CAP = (CAPACITY < 32);
   localparam logic [4:0] CAP5 = 5'(CAPACITY);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_element_out) && $stable(rsp_count)
         && $stable(rsp_highest_key) && $stable(rsp_lowest_key))
      else $error("response changed while stalled");

   // keys are reported in order, highest first
   a_key_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count != 5'd0 |-> rsp_highest_key >= rsp_lowest_key)
      else $error("highest key below lowest key");

   // empty queue reports zero summary
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_CAP && rsp_count == 5'd0 |->
         rsp_highest_key == 32'sd0 && rsp_lowest_key == 32'sd0)
      else $error("empty queue with non-zero keys");

   // a refused insert only happens on a full queue
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == CAP5)
      else $error("full status with spare room");

   // an empty-extract status means nothing is stored
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_CAP && rsp_status == ST_EMPTY |->
         rsp_count == 5'd0 && rsp_element_out == 32'sd0)
      else $error("empty status on a non-empty queue");
endmodule

bind sorted_array_priority_queue sapq_chk #(.CAPACITY(CAPACITY)) u_sapq_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_element_out(rsp_ch.element_out),
   .rsp_count      (rsp_ch.count),
   .rsp_highest_key(rsp_ch.highest_key),
   .rsp_lowest_key (rsp_ch.lowest_key)
);
